>>> design/assert_macros.svh
// Assertion macros shared by the scan serialiser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SSS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sss_pkg.sv
// Types, register indexes and segment font for the seven-segment scan serialiser.
package sss_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int COUNT_W     = 10;
   localparam int DIGIT_W     = 4;
   localparam int SELECT_W    = 4;
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_ON_AFTER   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLINK_WRAP_AFTER = 4'd1;

   localparam logic [COUNT_W-1:0] BLINK_ON_RESET   = 10'd200;
   localparam logic [COUNT_W-1:0] BLINK_WRAP_RESET = 10'd400;

   localparam logic [7:0] COLON_SEGMENT = 8'h08;

   // One scan slot waiting to be shifted out.
   typedef struct packed {
      logic [PATTERN_MAX-1:0] pattern;
      logic [SELECT_W-1:0]    select;
   } slot_type;

   // Segment font, bit set = segment lit; anything above nine is blank.
   function automatic logic [7:0] glyph(input logic [DIGIT_W-1:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0:    seg = 8'hF5;
         4'd1:    seg = 8'h05;
         4'd2:    seg = 8'hB3;
         4'd3:    seg = 8'h97;
         4'd4:    seg = 8'h47;
         4'd5:    seg = 8'hD6;
         4'd6:    seg = 8'hF6;
         4'd7:    seg = 8'h85;
         4'd8:    seg = 8'hF7;
         4'd9:    seg = 8'hD7;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

>>> design/sss_shifter.sv
// Output shifter: sends one slot pattern MSB first, one transfer per bit.
`include "assert_macros.svh"

module sss_shifter #(
   parameter int SEGMENT_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              slot_valid,
   input  sss_pkg::slot_type slot,
   output logic              slot_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_serial_bit,
   output logic [3:0]        rsp_digit_enable,
   output logic              rsp_latch_strobe
);
   import sss_pkg::*;

   localparam int CNT_W = $clog2(SEGMENT_BITS);

   logic                    valid_ff, valid_in;
   logic [SEGMENT_BITS-1:0] shift_ff, shift_in;
   logic [SELECT_W-1:0]     select_ff, select_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    last;
   logic                    advance;
   logic                    load;

   assign last    = (count_ff == CNT_W'(SEGMENT_BITS - 1));
   assign advance = valid_ff && !rsp_stall;
   assign load    = slot_valid && (!valid_ff || (advance && last));

   always_comb begin
      valid_in  = valid_ff;
      shift_in  = shift_ff;
      select_in = select_ff;
      count_in  = count_ff;
      if (load) begin
         valid_in  = 1'b1;
         shift_in  = slot.pattern[SEGMENT_BITS-1:0];
         select_in = slot.select;
         count_in  = '0;
      end else if (advance) begin
         if (last) begin
            valid_in = 1'b0;
            count_in = '0;
         end else begin
            shift_in = {shift_ff[SEGMENT_BITS-2:0], 1'b0};
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      shift_ff  <= shift_in;
      select_ff <= select_in;
   end

   assign slot_take        = load;
   assign rsp_valid        = valid_ff;
   assign rsp_serial_bit   = ~shift_ff[SEGMENT_BITS-1];
   assign rsp_latch_strobe = last;
   assign rsp_digit_enable = last ? select_ff : '0;

   `SSS_ASSERT(a_strobe_onehot, clock, reset, rsp_latch_strobe |-> $onehot0(rsp_digit_enable), "digit select not one-hot at strobe")
   `SSS_ASSERT(a_load_restarts, clock, reset, load |=> (valid_ff && count_ff == '0), "loaded slot does not start at first bit")
   `SSS_ASSERT(a_no_load_midway, clock, reset, (valid_ff && !last) |-> !load, "slot loaded over a pattern still shifting")
   `SSS_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !valid_ff || $past(load), "shifter valid after reset")

endmodule

>>> design/seven_segment_scan_serializer.sv
// Top level of the seven-segment scan serialiser: slot intake, scan and blink state.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | hour_tens, hour_ones, minute_tens, minute_ones
//   rsp_    | out       | rsp_valid/rsp_stall  | serial_bit, digit_enable, latch_strobe
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Each slot yields SEGMENT_BITS transfers, one per cycle while rsp_stall is low, set by the
// output shifter; the next slot waits in a holding register.
// The pattern is formed combinationally at the input transfer; scan and blink state advance there.
// Synchronous reset clears state and loads register defaults; csr_ready is always high.
// A stall on rsp_ holds the current bit; req_stall rises while the holding register is full.
module seven_segment_scan_serializer #(
   parameter int DIGITS       = 4,
   parameter int SEGMENT_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sss_pkg::DIGIT_W-1:0]        req_hour_tens,
   input  logic [sss_pkg::DIGIT_W-1:0]        req_hour_ones,
   input  logic [sss_pkg::DIGIT_W-1:0]        req_minute_tens,
   input  logic [sss_pkg::DIGIT_W-1:0]        req_minute_ones,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_serial_bit,
   output logic [sss_pkg::SELECT_W-1:0]       rsp_digit_enable,
   output logic                               rsp_latch_strobe,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sss_pkg::COUNT_W-1:0]        csr_data
);
   `include "assert_macros.svh"
   import sss_pkg::*;

   localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   logic [COUNT_W-1:0] on_after_ff, on_after_in;
   logic [COUNT_W-1:0] wrap_after_ff, wrap_after_in;
   logic [COUNT_W-1:0] blink_ff, blink_in;
   logic [COUNT_W-1:0] blink_inc;
   logic [POS_W-1:0]   scan_ff, scan_in;
   logic               pend_valid_ff, pend_valid_in;
   slot_type           pend_ff, pend_in;
   logic               req_accept;
   logic               csr_write;
   logic               slot_take;
   logic [2:0]         pos;
   logic [DIGIT_W-1:0] digit;
   logic [7:0]         seg;

   assign req_stall  = pend_valid_ff;
   assign req_accept = req_valid && !pend_valid_ff;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   assign pos = 3'(scan_ff);

   always_comb begin
      unique case (pos)
         3'd0:    digit = req_hour_tens;
         3'd1:    digit = req_hour_ones;
         3'd2:    digit = req_minute_tens;
         3'd3:    digit = req_minute_ones;
         default: digit = '0;
      endcase
   end

   always_comb begin
      seg = (pos > 3'd3) ? 8'h00 : glyph(digit);
      // blank a leading hour zero
      if (pos == 3'd0 && req_hour_tens == '0) begin
         seg = 8'h00;
      end
      // colon uses the count before this slot's increment
      if (pos == 3'd1 && blink_ff > on_after_ff) begin
         seg = seg | COLON_SEGMENT;
      end
   end

   assign blink_inc = blink_ff + COUNT_W'(1);

   always_comb begin
      on_after_in   = on_after_ff;
      wrap_after_in = wrap_after_ff;
      blink_in      = blink_ff;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (csr_write) begin
         if (csr_index == REG_BLINK_ON_AFTER) begin
            on_after_in = csr_data;
         end else if (csr_index == REG_BLINK_WRAP_AFTER) begin
            wrap_after_in = csr_data;
         end
      end
      if (req_accept) begin
         pend_valid_in  = 1'b1;
         pend_in.pattern = PATTERN_MAX'(seg);
         pend_in.select  = pos[2] ? '0 : (SELECT_W'(1) << pos[1:0]);
         blink_in       = (blink_inc > wrap_after_ff) ? '0 : blink_inc;
         scan_in        = (scan_ff == POS_W'(DIGITS - 1)) ? '0 : scan_ff + POS_W'(1);
      end else if (slot_take) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_after_ff   <= BLINK_ON_RESET;
         wrap_after_ff <= BLINK_WRAP_RESET;
         blink_ff      <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         on_after_ff   <= on_after_in;
         wrap_after_ff <= wrap_after_in;
         blink_ff      <= blink_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
      end
      pend_ff <= pend_in;
   end

   sss_shifter #(
      .SEGMENT_BITS(SEGMENT_BITS)
   ) u_shifter (
      .clock           (clock),
      .reset           (reset),
      .slot_valid      (pend_valid_ff),
      .slot            (pend_ff),
      .slot_take       (slot_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_serial_bit  (rsp_serial_bit),
      .rsp_digit_enable(rsp_digit_enable),
      .rsp_latch_strobe(rsp_latch_strobe)
   );

   `SSS_ASSERT(a_accept_fills, clock, reset, req_accept |=> pend_valid_ff, "accepted slot not held")
   `SSS_ASSERT(a_take_needs_slot, clock, reset, slot_take |-> pend_valid_ff, "shifter took an empty slot")
   `SSS_ASSERT(a_scan_in_range, clock, reset, scan_ff <= POS_W'(DIGITS - 1), "scan position out of range")
   `SSS_ASSERT(a_blink_bounded, clock, reset, req_accept |=> (blink_ff == '0 || blink_ff <= wrap_after_ff || $past(csr_write)), "blink count past wrap")

endmodule
